FILE: src/zass_pkg.sv
// Shared types and constants of the Z axis safety supervisor.
package zass_pkg;

	localparam int POS_W   = 24;
	localparam int ADC_W   = 16;
	localparam int LIM_W   = 24;
	localparam int SCALE_W = 16;
	localparam int WD_W    = 16;
	localparam int FAULT_W = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// item kinds
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_MOVE = 2'd1;
	localparam logic [1:0] MODE_STOP = 2'd2;

	// fault codes
	localparam logic [FAULT_W-1:0] FAULT_NONE         = 3'd0;
	localparam logic [FAULT_W-1:0] FAULT_TILT         = 3'd1;
	localparam logic [FAULT_W-1:0] FAULT_CRASH        = 3'd2;
	localparam logic [FAULT_W-1:0] FAULT_FORCE_HALT   = 3'd3;
	localparam logic [FAULT_W-1:0] FAULT_DEADMAN      = 3'd4;
	localparam logic [FAULT_W-1:0] FAULT_BUSY_REJECT  = 3'd5;
	localparam logic [FAULT_W-1:0] FAULT_FORCE_REJECT = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TILT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTACT_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_FORCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRASH_FORCE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCALE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SCALE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_SCALE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WD_TIMEOUT    = 3'd7;

	typedef struct packed {
		logic [1:0]              mode;
		logic                    move_up;
		logic signed [POS_W-1:0] pos_left_um;
		logic signed [POS_W-1:0] pos_right_um;
		logic signed [POS_W-1:0] pos_back_um;
		logic [ADC_W-1:0]        adc_left;
		logic [ADC_W-1:0]        adc_right;
		logic [ADC_W-1:0]        adc_back;
		logic                    sequence_running;
	} in_item_t;

	typedef struct packed {
		logic               emergency_stop;
		logic               start_motors;
		logic               drive_up;
		logic               fine_profile;
		logic               abort_sequence;
		logic [FAULT_W-1:0] fault;
		logic [LIM_W-1:0]   max_force_gf;
		logic [WD_W-1:0]    watchdog_left;
	} out_item_t;

	// force checks handed from the force unit to the control logic
	typedef struct packed {
		logic             over_contact;
		logic             over_process;
		logic             over_crash;
		logic [LIM_W-1:0] whole_gf;
	} force_flags_t;

	typedef struct packed {
		logic [LIM_W-1:0] contact_thr_gf;
		logic [LIM_W-1:0] process_limit_gf;
		logic [LIM_W-1:0] crash_force_limit_gf;
		logic [SCALE_W-1:0] left_scale;
		logic [SCALE_W-1:0] right_scale;
		logic [SCALE_W-1:0] back_scale;
	} force_cfg_t;

endpackage

FILE: src/zass_force.sv
// Force scaling of the three sensors, maximum and threshold compares.
module zass_force import zass_pkg::*; #(
	parameter int ADC_BITS        = 16,
	parameter int SCALE_FRAC_BITS = 8
) (
	input  logic [ADC_W-1:0] adc_left,
	input  logic [ADC_W-1:0] adc_right,
	input  logic [ADC_W-1:0] adc_back,
	input  force_cfg_t       cfg,
	output force_flags_t     flags
);

	localparam int PROD_W = ADC_BITS + SCALE_W;
	localparam int THR_W  = LIM_W + SCALE_FRAC_BITS;
	localparam int CMP_W  = ((PROD_W > THR_W) ? PROD_W : THR_W) + 1;

	logic [PROD_W-1:0] f_left, f_right, f_back, f_lr, f_max;
	logic [CMP_W-1:0]  f_ext, whole_ext;
	logic [CMP_W-1:0]  contact_fx, process_fx, crash_fx;

	assign f_left  = PROD_W'(adc_left[ADC_BITS-1:0]) * PROD_W'(cfg.left_scale);
	assign f_right = PROD_W'(adc_right[ADC_BITS-1:0]) * PROD_W'(cfg.right_scale);
	assign f_back  = PROD_W'(adc_back[ADC_BITS-1:0]) * PROD_W'(cfg.back_scale);

	assign f_lr  = (f_right > f_left) ? f_right : f_left;
	assign f_max = (f_back > f_lr) ? f_back : f_lr;
	assign f_ext = CMP_W'(f_max);

	// thresholds moved to the fixed-point scale so no fraction is dropped
	assign contact_fx = CMP_W'(cfg.contact_thr_gf) << SCALE_FRAC_BITS;
	assign process_fx = CMP_W'(cfg.process_limit_gf) << SCALE_FRAC_BITS;
	assign crash_fx   = CMP_W'(cfg.crash_force_limit_gf) << SCALE_FRAC_BITS;

	assign whole_ext = f_ext >> SCALE_FRAC_BITS;

	always_comb begin
		flags.over_contact = f_ext > contact_fx;
		flags.over_process = f_ext > process_fx;
		flags.over_crash   = f_ext > crash_fx;
		if (|whole_ext[CMP_W-1:LIM_W]) begin
			flags.whole_gf = {LIM_W{1'b1}};
		end else begin
			flags.whole_gf = whole_ext[LIM_W-1:0];
		end
	end

endmodule

FILE: src/zass_tilt.sv
// Pairwise tilt check of the three Z motor positions.
module zass_tilt import zass_pkg::*; (
	input  logic signed [POS_W-1:0] pos_left_um,
	input  logic signed [POS_W-1:0] pos_right_um,
	input  logic signed [POS_W-1:0] pos_back_um,
	input  logic [LIM_W-1:0]        max_tilt_delta_um,
	output logic                    tilt
);

	localparam int D_W = POS_W + 1;

	logic signed [D_W-1:0] d_lr, d_rb, d_lb;
	logic [D_W-1:0]        a_lr, a_rb, a_lb, lim;

	assign d_lr = D_W'(pos_left_um) - D_W'(pos_right_um);
	assign d_rb = D_W'(pos_right_um) - D_W'(pos_back_um);
	assign d_lb = D_W'(pos_left_um) - D_W'(pos_back_um);

	assign a_lr = d_lr[D_W-1] ? D_W'(-d_lr) : D_W'(d_lr);
	assign a_rb = d_rb[D_W-1] ? D_W'(-d_rb) : D_W'(d_rb);
	assign a_lb = d_lb[D_W-1] ? D_W'(-d_lb) : D_W'(d_lb);

	assign lim  = D_W'(max_tilt_delta_um);
	assign tilt = (a_lr > lim) || (a_rb > lim) || (a_lb > lim);

endmodule

FILE: src/zass_ctrl.sv
// Decision logic: tick checks, watchdog, manual move and stop handling.
module zass_ctrl import zass_pkg::*; (
	input  logic [1:0]      mode,
	input  logic            move_up,
	input  logic            sequence_running,
	input  logic            tilt,
	input  force_flags_t    flags,
	input  logic [WD_W-1:0] watchdog_timeout,
	input  logic [WD_W-1:0] wd_q,
	input  logic            manual_up_q,
	output logic [WD_W-1:0] wd_next,
	output logic            manual_up_next,
	output out_item_t       result
);

	always_comb begin
		wd_next        = wd_q;
		manual_up_next = manual_up_q;
		result.emergency_stop = 1'b0;
		result.start_motors   = 1'b0;
		result.fine_profile   = 1'b0;
		result.abort_sequence = 1'b0;
		result.fault          = FAULT_NONE;
		case (mode)
			MODE_TICK: begin
				if (tilt) begin
					wd_next = '0;
					result.emergency_stop = 1'b1;
					result.abort_sequence = sequence_running;
					result.fault          = FAULT_TILT;
				end else if (flags.over_crash) begin
					wd_next = '0;
					result.emergency_stop = 1'b1;
					result.abort_sequence = sequence_running;
					result.fault          = FAULT_CRASH;
				end else if (wd_q != '0) begin
					if (flags.over_process && manual_up_q) begin
						wd_next = '0;
						result.emergency_stop = 1'b1;
						result.fault          = FAULT_FORCE_HALT;
					end else begin
						wd_next = wd_q - 1'b1;
						// last count expiring
						if (wd_q == WD_W'(1)) begin
							result.emergency_stop = 1'b1;
							result.fault          = FAULT_DEADMAN;
						end
					end
				end
			end
			MODE_MOVE: begin
				if (sequence_running) begin
					result.fault = FAULT_BUSY_REJECT;
				end else if (flags.over_process && move_up) begin
					result.fault = FAULT_FORCE_REJECT;
				end else begin
					manual_up_next       = move_up;
					result.fine_profile  = flags.over_contact;
					result.start_motors  = (wd_q == '0);
					wd_next              = watchdog_timeout;
				end
			end
			MODE_STOP: begin
				wd_next = '0;
				result.emergency_stop = 1'b1;
			end
			default: begin
			end
		endcase
		result.drive_up      = manual_up_next;
		result.max_force_gf  = flags.whole_gf;
		result.watchdog_left = wd_next;
	end

endmodule

FILE: src/z_axis_safety_supervisor.sv
// Top level of the Z axis safety supervisor.
//
//  channel | signals                     | item
//  --------+-----------------------------+------------------------------
//  in      | in_valid, in_stall, in_data | tick, manual move or stop
//  out     | out_valid, out_stall, out_data | one result per input item
//  cfg     | cfg_we, cfg_index, cfg_data | register write, no read-back
//
// One item per cycle while the output is not stalled. An item is registered on entry,
// checked by one pass of compares and three 16x16 multiplies, and moves into the
// result register once that register is empty or being read. The watchdog and
// direction state update as the item moves into the result register. Reset
// disarms the watchdog, sets the direction down and loads the register defaults.
// A stalled result register holds the input stage; input stall rises only when
// both are full and the output is stalled.
module z_axis_safety_supervisor import zass_pkg::*; #(
	parameter int ADC_BITS        = 16,
	parameter int SCALE_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LIM_W-1:0]  max_tilt_q;
	force_cfg_t        force_cfg_q;
	logic [WD_W-1:0]   wd_timeout_q;

	logic              valid_s1;
	in_item_t          item_s1;
	logic              adv_s1;

	logic [WD_W-1:0]   wd_q, wd_next;
	logic              manual_up_q, manual_up_next;

	logic              out_valid_q;
	out_item_t         out_data_q;

	logic              tilt;
	force_flags_t      flags;
	out_item_t         result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tilt_q                       <= LIM_W'(2000);
			force_cfg_q.contact_thr_gf       <= LIM_W'(50);
			force_cfg_q.process_limit_gf     <= LIM_W'(5000);
			force_cfg_q.crash_force_limit_gf <= LIM_W'(10000);
			force_cfg_q.left_scale           <= SCALE_W'(256);
			force_cfg_q.right_scale          <= SCALE_W'(256);
			force_cfg_q.back_scale           <= SCALE_W'(256);
			wd_timeout_q                     <= WD_W'(50);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_TILT:      max_tilt_q <= cfg_data[LIM_W-1:0];
				REG_CONTACT_THR:   force_cfg_q.contact_thr_gf <= cfg_data[LIM_W-1:0];
				REG_PROCESS_FORCE: force_cfg_q.process_limit_gf <= cfg_data[LIM_W-1:0];
				REG_CRASH_FORCE:   force_cfg_q.crash_force_limit_gf <= cfg_data[LIM_W-1:0];
				REG_LEFT_SCALE:    force_cfg_q.left_scale  <= cfg_data[SCALE_W-1:0];
				REG_RIGHT_SCALE:   force_cfg_q.right_scale <= cfg_data[SCALE_W-1:0];
				REG_BACK_SCALE:    force_cfg_q.back_scale  <= cfg_data[SCALE_W-1:0];
				REG_WD_TIMEOUT:    wd_timeout_q <= cfg_data[WD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	zass_tilt u_tilt (
		.pos_left_um       (item_s1.pos_left_um),
		.pos_right_um      (item_s1.pos_right_um),
		.pos_back_um       (item_s1.pos_back_um),
		.max_tilt_delta_um (max_tilt_q),
		.tilt              (tilt)
	);

	zass_force #(
		.ADC_BITS        (ADC_BITS),
		.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
	) u_force (
		.adc_left  (item_s1.adc_left),
		.adc_right (item_s1.adc_right),
		.adc_back  (item_s1.adc_back),
		.cfg       (force_cfg_q),
		.flags     (flags)
	);

	zass_ctrl u_ctrl (
		.mode             (item_s1.mode),
		.move_up          (item_s1.move_up),
		.sequence_running (item_s1.sequence_running),
		.tilt             (tilt),
		.flags            (flags),
		.watchdog_timeout (wd_timeout_q),
		.wd_q             (wd_q),
		.manual_up_q      (manual_up_q),
		.wd_next          (wd_next),
		.manual_up_next   (manual_up_next),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_q        <= '0;
			manual_up_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			wd_q        <= wd_next;
			manual_up_q <= manual_up_next;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sim/tb_z_axis_safety_supervisor.sv
// Self-checking testbench for the Z axis safety supervisor: directed and random items.
`timescale 1ns / 100ps

module tb_z_axis_safety_supervisor import zass_pkg::*;;

	localparam int FRAC_BITS   = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEG_ITEMS   = 200;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [LIM_W-1:0]   max_tilt;
		logic [LIM_W-1:0]   contact_thr;
		logic [LIM_W-1:0]   process_thr;
		logic [LIM_W-1:0]   crash_thr;
		logic [SCALE_W-1:0] scale_l;
		logic [SCALE_W-1:0] scale_r;
		logic [SCALE_W-1:0] scale_b;
		logic [WD_W-1:0]    wd_timeout;
	} regs_t;

	localparam regs_t DEFAULT_REGS = '{24'd2000, 24'd50, 24'd5000, 24'd10000,
		16'd256, 16'd256, 16'd256, 16'd50};
	localparam regs_t ONES_REGS = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
	localparam regs_t ZERO_REGS = '0;

	class safety_scoreboard;
		logic [LIM_W-1:0]   tilt_lim, contact_thr, process_thr, crash_thr;
		logic [SCALE_W-1:0] scale_l, scale_r, scale_b;
		logic [WD_W-1:0]    wd_timeout;
		logic [WD_W-1:0]    wd_count;
		logic               dir_up;
		out_item_t          pending_results[$];
		int                 errors;
		int                 items_seen;
		int                 start_count;
		int                 fault_count[8];

		function new();
			tilt_lim    = 24'd2000;
			contact_thr = 24'd50;
			process_thr = 24'd5000;
			crash_thr   = 24'd10000;
			scale_l     = 16'd256;
			scale_r     = 16'd256;
			scale_b     = 16'd256;
			wd_timeout  = 16'd50;
			wd_count    = '0;
			dir_up      = 1'b0;
			errors      = 0;
			items_seen  = 0;
			start_count = 0;
			foreach (fault_count[i]) fault_count[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_MAX_TILT:      tilt_lim = val;
				REG_CONTACT_THR:   contact_thr = val;
				REG_PROCESS_FORCE: process_thr = val;
				REG_CRASH_FORCE:   crash_thr = val;
				REG_LEFT_SCALE:    scale_l = val[SCALE_W-1:0];
				REG_RIGHT_SCALE:   scale_r = val[SCALE_W-1:0];
				REG_BACK_SCALE:    scale_b = val[SCALE_W-1:0];
				REG_WD_TIMEOUT:    wd_timeout = val[WD_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned span(longint a, longint b);
			return (a > b) ? a - b : b - a;
		endfunction

		// compare at full precision: product against threshold shifted up by the fraction
		function bit exceeds(longint unsigned f, logic [LIM_W-1:0] thr);
			return f > (64'(thr) << FRAC_BITS);
		endfunction

		function out_item_t next_result(in_item_t it);
			out_item_t       r;
			longint unsigned f_l, f_r, f_b, f_max, lim, whole;
			longint          p_l, p_r, p_b;
			bit              over_proc, tilted;
			r = '0;
			f_l = 64'(it.adc_left) * 64'(scale_l);
			f_r = 64'(it.adc_right) * 64'(scale_r);
			f_b = 64'(it.adc_back) * 64'(scale_b);
			f_max = f_l;
			if (f_r > f_max) f_max = f_r;
			if (f_b > f_max) f_max = f_b;
			p_l = $signed(it.pos_left_um);
			p_r = $signed(it.pos_right_um);
			p_b = $signed(it.pos_back_um);
			lim = 64'(tilt_lim);
			tilted = span(p_l, p_r) > lim || span(p_r, p_b) > lim || span(p_l, p_b) > lim;
			over_proc = exceeds(f_max, process_thr);
			case (it.mode)
				MODE_TICK: begin
					if (tilted) begin
						wd_count = '0;
						r.emergency_stop = 1'b1;
						r.abort_sequence = it.sequence_running;
						r.fault = FAULT_TILT;
					end else if (exceeds(f_max, crash_thr)) begin
						wd_count = '0;
						r.emergency_stop = 1'b1;
						r.abort_sequence = it.sequence_running;
						r.fault = FAULT_CRASH;
					end else if (wd_count != '0) begin
						if (over_proc && dir_up) begin
							wd_count = '0;
							r.emergency_stop = 1'b1;
							r.fault = FAULT_FORCE_HALT;
						end else begin
							wd_count = wd_count - 1'b1;
							if (wd_count == '0) begin
								r.emergency_stop = 1'b1;
								r.fault = FAULT_DEADMAN;
							end
						end
					end
				end
				MODE_MOVE: begin
					if (it.sequence_running) begin
						r.fault = FAULT_BUSY_REJECT;
					end else if (over_proc && it.move_up) begin
						r.fault = FAULT_FORCE_REJECT;
					end else begin
						dir_up = it.move_up;
						r.fine_profile = exceeds(f_max, contact_thr);
						r.start_motors = (wd_count == '0);
						wd_count = wd_timeout;
					end
				end
				MODE_STOP: begin
					wd_count = '0;
					r.emergency_stop = 1'b1;
				end
				default: ;
			endcase
			whole = f_max >> FRAC_BITS;
			r.drive_up = dir_up;
			r.max_force_gf = (whole > 64'hFFFFFF) ? 24'hFFFFFF : whole[LIM_W-1:0];
			r.watchdog_left = wd_count;
			return r;
		endfunction

		function void record_item(in_item_t it);
			out_item_t r;
			r = next_result(it);
			pending_results.push_back(r);
			items_seen++;
			fault_count[r.fault]++;
			if (r.start_motors) start_count++;
		endfunction

		function void compare(string name, logic [LIM_W-1:0] exp, logic [LIM_W-1:0] act);
			if (act !== exp) begin
				$error("%s: expected %0d, got %0d", name, exp, act);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding: %h", got);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			compare("emergency_stop", 24'(exp.emergency_stop), 24'(got.emergency_stop));
			compare("start_motors", 24'(exp.start_motors), 24'(got.start_motors));
			compare("drive_up", 24'(exp.drive_up), 24'(got.drive_up));
			compare("fine_profile", 24'(exp.fine_profile), 24'(got.fine_profile));
			compare("abort_sequence", 24'(exp.abort_sequence), 24'(got.abort_sequence));
			compare("fault", 24'(exp.fault), 24'(got.fault));
			compare("max_force_gf", exp.max_force_gf, got.max_force_gf);
			compare("watchdog_left", 24'(exp.watchdog_left), 24'(got.watchdog_left));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	safety_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;

	z_axis_safety_supervisor #(
		.ADC_BITS(16),
		.SCALE_FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #1 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	function automatic in_item_t make_item(logic [1:0] mode, int up, int pl, int pr, int pb,
			int al, int ar, int ab, int run);
		in_item_t it;
		it.mode = mode;
		it.move_up = up[0];
		it.pos_left_um = pl[POS_W-1:0];
		it.pos_right_um = pr[POS_W-1:0];
		it.pos_back_um = pb[POS_W-1:0];
		it.adc_left = al[ADC_W-1:0];
		it.adc_right = ar[ADC_W-1:0];
		it.adc_back = ab[ADC_W-1:0];
		it.sequence_running = run[0];
		return it;
	endfunction

	// raw sample within two counts of the raw value that scales to the threshold
	function automatic logic [ADC_W-1:0] adc_near(logic [LIM_W-1:0] thr, logic [SCALE_W-1:0] sc);
		longint t;
		if (sc == '0) return ADC_W'($urandom);
		t = ((longint'(thr) << FRAC_BITS) / longint'(sc)) + longint'($urandom_range(4)) - 2;
		if (t < 0) t = 0;
		if (t > 65535) t = 65535;
		return t[ADC_W-1:0];
	endfunction

	function automatic in_item_t rand_item();
		in_item_t         it;
		int               sel, base, lim, k, primary;
		int               pos[3];
		logic [LIM_W-1:0] thr;
		logic [SCALE_W-1:0] sc[3];
		logic [ADC_W-1:0] adc[3];
		sel = $urandom_range(99);
		if (sel < 55) it.mode = MODE_TICK;
		else if (sel < 88) it.mode = MODE_MOVE;
		else if (sel < 97) it.mode = MODE_STOP;
		else it.mode = MODE_UNUSED;
		it.move_up = 1'($urandom_range(1));
		it.sequence_running = ($urandom_range(99) < 12);

		lim = (sb.tilt_lim > 24'd1000000) ? 1000000 : int'(sb.tilt_lim);
		base = int'($urandom_range(8000000)) - 4000000;
		sel = $urandom_range(99);
		if (sel < 15) begin
			foreach (pos[i]) pos[i] = int'($urandom);
		end else if (sel < 35) begin
			// one motor right at the tilt limit (capped at 1000000) or one past it
			foreach (pos[i]) pos[i] = base;
			k = $urandom_range(2);
			if ($urandom_range(1)) pos[k] = base + lim + int'($urandom_range(1));
			else pos[k] = base - lim - int'($urandom_range(1));
		end else begin
			foreach (pos[i]) pos[i] = base + int'($urandom_range(lim)) - lim / 2;
		end
		it.pos_left_um = pos[0][POS_W-1:0];
		it.pos_right_um = pos[1][POS_W-1:0];
		it.pos_back_um = pos[2][POS_W-1:0];

		sc[0] = sb.scale_l;
		sc[1] = sb.scale_r;
		sc[2] = sb.scale_b;
		sel = $urandom_range(99);
		if (sel < 10) begin
			foreach (adc[i]) adc[i] = ADC_W'($urandom);
		end else if (sel < 35) begin
			foreach (adc[i]) adc[i] = ADC_W'($urandom_range(adc_near(sb.contact_thr, sc[i])));
		end else begin
			k = $urandom_range(2);
			thr = (k == 0) ? sb.contact_thr : (k == 1) ? sb.process_thr : sb.crash_thr;
			primary = $urandom_range(2);
			foreach (adc[i]) begin
				if (i == primary) adc[i] = adc_near(thr, sc[i]);
				else adc[i] = ADC_W'($urandom_range(adc_near(thr, sc[i])));
			end
		end
		it.adc_left = adc[0];
		it.adc_right = adc[1];
		it.adc_back = adc[2];
		return it;
	endfunction

	function automatic regs_t random_regs(bit wide_scale);
		regs_t r;
		r.max_tilt = LIM_W'($urandom_range(20000, 50));
		r.contact_thr = LIM_W'($urandom_range(2000));
		r.process_thr = r.contact_thr + LIM_W'($urandom_range(20000, 1));
		r.crash_thr = r.process_thr + LIM_W'($urandom_range(40000, 1));
		r.scale_l = wide_scale ? SCALE_W'($urandom_range(65535, 1024))
			: SCALE_W'($urandom_range(1024, 64));
		r.scale_r = wide_scale ? SCALE_W'($urandom_range(65535, 1024))
			: SCALE_W'($urandom_range(1024, 64));
		r.scale_b = wide_scale ? 16'hFFFF : SCALE_W'($urandom_range(1024, 64));
		r.wd_timeout = WD_W'($urandom_range(12, 1));
		return r;
	endfunction

	// called at a falling edge; leaves cfg_we high for the caller to drop
	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_regs(regs_t r);
		reg_write(REG_MAX_TILT, r.max_tilt);
		reg_write(REG_CONTACT_THR, r.contact_thr);
		reg_write(REG_PROCESS_FORCE, r.process_thr);
		reg_write(REG_CRASH_FORCE, r.crash_thr);
		reg_write(REG_LEFT_SCALE, 24'(r.scale_l));
		reg_write(REG_RIGHT_SCALE, 24'(r.scale_r));
		reg_write(REG_BACK_SCALE, 24'(r.scale_b));
		reg_write(REG_WD_TIMEOUT, 24'(r.wd_timeout));
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.record_item(it);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_TILT;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items at the reset register values
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_MOVE, 0, 10, 10, 10, 10, 0, 0, 0));
		send_item(make_item(MODE_MOVE, 1, 0, 0, 0, 0, 51, 0, 0));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 50, 0, 0, 0));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 5001, 0));
		send_item(make_item(MODE_MOVE, 1, 0, 0, 0, 5001, 0, 0, 0));
		send_item(make_item(MODE_MOVE, 1, 0, 0, 0, 10, 0, 0, 1));
		send_item(make_item(MODE_MOVE, 1, 0, 0, 0, 0, 5000, 0, 0));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 10000, 0, 0));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 10000, 0, 0, 0));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 10001, 1));
		send_item(make_item(MODE_TICK, 0, 0, 2000, 1000, 0, 0, 0, 0));
		send_item(make_item(MODE_TICK, 0, -1000, 0, 1001, 0, 0, 0, 1));
		send_item(make_item(MODE_TICK, 0, 8388607, -8388608, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_MOVE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_STOP, 1, 0, 0, 0, 0, 0, 0, 1));
		send_item(make_item(MODE_UNUSED, 1, -1, -1, -1, 65535, 65535, 65535, 1));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 65535, 65535, 65535, 0));
		send_item(make_item(MODE_TICK, 1, 0, 5000, 0, 20000, 0, 0, 1));

		// dead-man expiry with a short timeout
		wait_drained();
		reg_write(REG_WD_TIMEOUT, 24'd2);
		cfg_we <= 1'b0;
		send_item(make_item(MODE_MOVE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0));

		// zero timeout keeps the watchdog disarmed, so every move restarts
		wait_drained();
		reg_write(REG_WD_TIMEOUT, 24'd0);
		cfg_we <= 1'b0;
		send_item(make_item(MODE_MOVE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_MOVE, 1, 0, 0, 0, 0, 0, 100, 0));

		for (int seg = 0; seg < 8; seg++) begin
			wait_drained();
			case (seg)
				0: set_regs(DEFAULT_REGS);
				1: set_regs(ONES_REGS);
				2: set_regs(ZERO_REGS);
				5: set_regs(random_regs(1'b1));
				default: set_regs(random_regs(1'b0));
			endcase
			case (seg % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 78; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 78; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			for (int n = 0; n < SEG_ITEMS; n++) begin
				if (n == SEG_ITEMS / 2 || $urandom_range(199) == 0) wait_drained();
				send_item(rand_item());
			end
		end

		wait_drained();
		$display("Checked %0d items over 11 register settings and four idling patterns",
			sb.items_seen);
		$display("Faults: tilt %0d, crash %0d, halt %0d, dead-man %0d, busy %0d, %s %0d",
			sb.fault_count[FAULT_TILT], sb.fault_count[FAULT_CRASH],
			sb.fault_count[FAULT_FORCE_HALT], sb.fault_count[FAULT_DEADMAN],
			sb.fault_count[FAULT_BUSY_REJECT], "force reject",
			sb.fault_count[FAULT_FORCE_REJECT]);
		$display("Motor starts: %0d", sb.start_count);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
